### sv/vttt_pkg.sv
// Shared types and codes for the vote threshold tally table.
package vttt_pkg;

    // Field widths of one beat
    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 64;
    localparam int ID_W     = 4 * WORD_W;
    localparam int KIND_W   = 8;
    localparam int THRESH_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int CODE_W   = 2;

    localparam int S_TDATA_W = 264;  // id words, vote kind
    localparam int M_TDATA_W = 104;  // result fields, padded to whole bytes

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd15;

    // Operation selector
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_VOTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Vote kinds
    localparam logic [KIND_W-1:0] KIND_PREFER = 8'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 8'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 8'd2;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [CODE_W-1:0] ERR_PRESENT = 2'd1;
    localparam logic [CODE_W-1:0] ERR_UNKNOWN = 2'd2;
    localparam logic [CODE_W-1:0] ERR_FULL    = 2'd3;

    // Block status codes
    localparam logic [CODE_W-1:0] BST_UNKNOWN    = 2'd0;
    localparam logic [CODE_W-1:0] BST_PROCESSING = 2'd1;
    localparam logic [CODE_W-1:0] BST_ACCEPTED   = 2'd2;
    localparam logic [CODE_W-1:0] BST_REJECTED   = 2'd3;

    // Decision events
    localparam logic [CODE_W-1:0] EVT_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] EVT_ACCEPT = 2'd1;
    localparam logic [CODE_W-1:0] EVT_REJECT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_ctrl_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic do_cmp;
        logic do_upd;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

### sv/vttt_ctrl.sv
// Sequencer: capture, compare, update.
module vttt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  vttt_pkg::t_stat i_stat,
    output vttt_pkg::t_cmd  o_cmd
);
    import vttt_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_stat.out_free) n_state = i_in_valid ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        w_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
            end
            S_CMP: begin
                o_cmd.do_cmp = 1'b1;
            end
            S_UPD: begin
                w_ready      = i_stat.out_free;
                o_cmd.do_upd = i_stat.out_free;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
        o_cmd.load_in = w_ready & i_in_valid;
    end

    assign o_in_ready = w_ready;

endmodule

### sv/vttt_dp.sv
// Table, key compare, vote counters, totals and result register.
module vttt_dp #(
    parameter  int ENTRIES      = 16,
    parameter  int COUNTER_BITS = 16,
    localparam int IW           = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vttt_pkg::t_cmd                   i_cmd,
    output vttt_pkg::t_stat                  o_stat,
    input  logic [vttt_pkg::FUNC_W-1:0]      i_func,
    input  logic [vttt_pkg::ID_W-1:0]        i_id,
    input  logic [vttt_pkg::KIND_W-1:0]      i_vote_kind,
    input  logic                             i_cfg_wr_en,
    input  logic [vttt_pkg::THRESH_W-1:0]    i_cfg_wr_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_ok,
    output logic [vttt_pkg::CODE_W-1:0]      o_error_code,
    output logic [vttt_pkg::CODE_W-1:0]      o_block_state,
    output logic [vttt_pkg::CODE_W-1:0]      o_decision_event,
    output logic [vttt_pkg::TOTAL_W-1:0]     o_accepted_total,
    output logic [vttt_pkg::TOTAL_W-1:0]     o_rejected_total,
    output logic [vttt_pkg::TOTAL_W-1:0]     o_votes_total
);
    import vttt_pkg::*;

    localparam int CW = COUNTER_BITS;

    // Captured beat
    logic [FUNC_W-1:0]   r_func;
    logic [ID_W-1:0]     r_id;
    logic [KIND_W-1:0]   r_kind;

    // Table
    logic [ID_W-1:0]     r_key     [ENTRIES];
    logic [CODE_W-1:0]   r_status  [ENTRIES];
    logic [CW-1:0]       r_favor   [ENTRIES];
    logic [CW-1:0]       r_against [ENTRIES];

    logic [THRESH_W-1:0] r_thresh;
    logic [TOTAL_W-1:0]  r_acc, r_rej, r_votes;

    // Compare results
    logic                r_hit, r_free_ok;
    logic [IW-1:0]       r_hidx, r_fidx;
    logic                w_hit, w_free_ok;
    logic [IW-1:0]       w_hidx, w_fidx;

    // Update
    logic [CODE_W-1:0]   w_cur_st, n_st;
    logic [CW-1:0]       w_fav, w_ag, n_fav, n_ag;
    logic                w_add_wr, w_vote_wr;
    logic                n_ok;
    logic [CODE_W-1:0]   n_err, n_bst, n_evt;
    logic [TOTAL_W-1:0]  n_acc, n_rej, n_votes;

    // Result register
    logic                r_out_valid;
    logic                r_ok;
    logic [CODE_W-1:0]   r_err, r_bst, r_evt;
    logic [TOTAL_W-1:0]  r_out_acc, r_out_rej, r_out_votes;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_id   <= i_id;
            r_kind <= i_vote_kind;
        end
    end

    // Parallel compare, one lane per entry; pick the lowest free entry
    always_comb begin
        w_hit     = 1'b0;
        w_hidx    = '0;
        w_free_ok = 1'b0;
        w_fidx    = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (r_status[e] != BST_UNKNOWN && r_key[e] == r_id) begin
                w_hit  = 1'b1;
                w_hidx = w_hidx | IW'(e);
            end
            if (r_status[e] == BST_UNKNOWN && !w_free_ok) begin
                w_free_ok = 1'b1;
                w_fidx    = IW'(e);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_cmp) begin
            r_hit     <= w_hit;
            r_hidx    <= w_hidx;
            r_free_ok <= w_free_ok;
            r_fidx    <= w_fidx;
        end
    end

    // Read-modify-write of the matched entry
    always_comb begin
        w_cur_st  = r_status[r_hidx];
        w_fav     = r_favor[r_hidx];
        w_ag      = r_against[r_hidx];
        n_fav     = w_fav;
        n_ag      = w_ag;
        n_st      = w_cur_st;
        w_add_wr  = 1'b0;
        w_vote_wr = 1'b0;
        n_ok      = 1'b0;
        n_err     = ERR_NONE;
        n_bst     = BST_UNKNOWN;
        n_evt     = EVT_NONE;
        n_acc     = r_acc;
        n_rej     = r_rej;
        n_votes   = r_votes;
        unique case (r_func)
            FUNC_ADD: begin
                if (r_hit) begin
                    n_err = ERR_PRESENT;
                    n_bst = w_cur_st;
                end else if (!r_free_ok) begin
                    n_err = ERR_FULL;
                end else begin
                    w_add_wr = 1'b1;
                    n_ok     = 1'b1;
                    n_bst    = BST_PROCESSING;
                end
            end
            FUNC_VOTE: begin
                if (!r_hit) begin
                    n_err = ERR_UNKNOWN;
                end else begin
                    w_vote_wr = 1'b1;
                    if (r_votes != '1) n_votes = r_votes + 1'b1;
                    if (r_kind == KIND_PREFER || r_kind == KIND_ACCEPT) begin
                        if (w_fav != '1) n_fav = w_fav + 1'b1;
                    end else if (r_kind == KIND_REJECT) begin
                        if (w_ag != '1) n_ag = w_ag + 1'b1;
                    end
                    // Decide only once, acceptance first
                    if (w_cur_st == BST_PROCESSING) begin
                        if (32'(n_fav) >= 32'(r_thresh)) begin
                            n_st  = BST_ACCEPTED;
                            n_evt = EVT_ACCEPT;
                            if (r_acc != '1) n_acc = r_acc + 1'b1;
                        end else if (32'(n_ag) >= 32'(r_thresh)) begin
                            n_st  = BST_REJECTED;
                            n_evt = EVT_REJECT;
                            if (r_rej != '1) n_rej = r_rej + 1'b1;
                        end
                    end
                    n_ok  = 1'b1;
                    n_bst = n_st;
                end
            end
            FUNC_QUERY: begin
                if (!r_hit) begin
                    n_err = ERR_UNKNOWN;
                end else begin
                    n_ok  = 1'b1;
                    n_bst = w_cur_st;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Control state: status, totals, threshold, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_status[e] <= BST_UNKNOWN;
            end
            r_acc       <= '0;
            r_rej       <= '0;
            r_votes     <= '0;
            r_thresh    <= THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_thresh <= i_cfg_wr_data;
            if (i_cmd.do_upd) begin
                if (w_add_wr) r_status[r_fidx] <= BST_PROCESSING;
                else if (w_vote_wr) r_status[r_hidx] <= n_st;
                r_acc   <= n_acc;
                r_rej   <= n_rej;
                r_votes <= n_votes;
            end
            if (i_cmd.do_upd) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload: keys, counters, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_upd) begin
            if (w_add_wr) begin
                r_key[r_fidx]     <= r_id;
                r_favor[r_fidx]   <= '0;
                r_against[r_fidx] <= '0;
            end else if (w_vote_wr) begin
                r_favor[r_hidx]   <= n_fav;
                r_against[r_hidx] <= n_ag;
            end
            r_ok        <= n_ok;
            r_err       <= n_err;
            r_bst       <= n_bst;
            r_evt       <= n_evt;
            r_out_acc   <= n_acc;
            r_out_rej   <= n_rej;
            r_out_votes <= n_votes;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_ok;
    assign o_error_code     = r_err;
    assign o_block_state    = r_bst;
    assign o_decision_event = r_evt;
    assign o_accepted_total = r_out_acc;
    assign o_rejected_total = r_out_rej;
    assign o_votes_total    = r_out_votes;

endmodule

### sv/vote_threshold_tally_table_unit.sv
// Top level of the vote threshold tally table.
// Keeps up to ENTRIES 256-bit block ids, each with a status and two
// saturating vote counters of COUNTER_BITS. Each input beat adds a block
// (tuser 0), records a vote (tuser 1) or queries a block (tuser 2); tuser 3
// is ignored and still returns one result beat. Prefer and accept votes
// count toward acceptance, reject votes toward rejection; a processing
// block whose count reaches the threshold is accepted or rejected once,
// acceptance first. Each item has a compare step, which checks the id
// against every stored key in parallel and registers the match and
// lowest free entry, then an update step, which reads, updates and
// writes back the matched counters and loads the result register. A new
// beat is taken in the update cycle while the result register drains; a
// result still waiting in that register holds the update cycle, and with
// it the next beat, until the result beat is taken. The threshold resets
// to 15 and may be rewritten only while no beat is in flight. There is no
// clearing pass: the table is usable right after reset.
module vote_threshold_tally_table_unit #(
    parameter int ENTRIES      = 16,
    parameter int COUNTER_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Threshold register
    input  logic                                i_cfg_wr_en,
    input  logic [vttt_pkg::THRESH_W-1:0]       i_cfg_wr_data,
    // Command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [63:0] id_word0, [127:64] id_word1, [191:128] id_word2,
    // [255:192] id_word3, [263:256] vote_kind
    input  logic [vttt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] func
    input  logic [vttt_pkg::FUNC_W-1:0]         s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] ok, [2:1] error_code, [4:3] block_state, [6:5] decision_event,
    // [38:7] accepted_total, [70:39] rejected_total, [102:71] votes_total,
    // [103] zero
    output logic [vttt_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import vttt_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic                w_ok;
    logic [CODE_W-1:0]   w_err, w_bst, w_evt;
    logic [TOTAL_W-1:0]  w_acc, w_rej, w_votes;

    vttt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    vttt_dp #(
        .ENTRIES      (ENTRIES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_func           (s_axis_tuser),
        .i_id             (s_axis_tdata[ID_W-1:0]),
        .i_vote_kind      (s_axis_tdata[ID_W +: KIND_W]),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_ok             (w_ok),
        .o_error_code     (w_err),
        .o_block_state    (w_bst),
        .o_decision_event (w_evt),
        .o_accepted_total (w_acc),
        .o_rejected_total (w_rej),
        .o_votes_total    (w_votes)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = {1'b0, w_votes, w_rej, w_acc, w_evt, w_bst, w_err, w_ok};

endmodule

### sv/vttt_checker.sv
// Port-level checks for the vote threshold tally table, bound to the top.
module vttt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [vttt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import vttt_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Compare cycle follows every accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("beat accepted during compare cycle");

    // A decision only comes from a successful vote
    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6:5] != EVT_NONE |->
            m_axis_tdata[0] && m_axis_tdata[2:1] == ERR_NONE)
        else $error("decision reported on a failed item");

endmodule

bind vote_threshold_tally_table_unit vttt_checker u_vttt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/tb.sv
// Self-checking bench for the vote threshold tally table: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb;
    import vttt_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int CNT_W       = 16;
    localparam int QUIET_LIMIT = 5000;  // cycles with no beat on either side

    // Selector the block ignores, and vote kinds that count toward no side
    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [KIND_W-1:0] KIND_NONE_HI = 8'hFF;
    localparam logic [KIND_W-1:0] KIND_NONE_MD = 8'h80;

    localparam logic [ID_W-1:0] ID_ZERO = '0;
    localparam logic [ID_W-1:0] ID_ONES = '1;

    // One result beat, first member in the top bits
    typedef struct packed {
        logic [TOTAL_W-1:0] vote_total;
        logic [TOTAL_W-1:0] rej_total;
        logic [TOTAL_W-1:0] acc_total;
        logic [CODE_W-1:0]  evt;
        logic [CODE_W-1:0]  bst;
        logic [CODE_W-1:0]  err;
        logic               ok;
    } t_tally_beat;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [THRESH_W-1:0]  i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [FUNC_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    vote_threshold_tally_table_unit #(
        .ENTRIES      (NUM_SLOTS),
        .COUNTER_BITS (CNT_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the table: keys, status and vote counts per entry, plus totals.
    // Entries fill from the bottom and are never freed, so the occupied ones
    // are always 0 .. slots_used-1.
    logic [ID_W-1:0]     tbl_key     [NUM_SLOTS];
    logic [CODE_W-1:0]   tbl_status  [NUM_SLOTS];
    logic [CNT_W-1:0]    tbl_favor   [NUM_SLOTS];
    logic [CNT_W-1:0]    tbl_against [NUM_SLOTS];
    logic [TOTAL_W-1:0]  acc_total   = '0;
    logic [TOTAL_W-1:0]  rej_total   = '0;
    logic [TOTAL_W-1:0]  vote_total  = '0;
    logic [THRESH_W-1:0] alpha       = THRESH_RESET;
    int                  slots_used  = 0;

    t_tally_beat awaited_tallies[$];
    int          mismatches     = 0;
    int          sender_gap_pct = 0;
    int          sink_stall_pct = 0;
    bit          running        = 1'b0;
    int          quiet_cycles   = 0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_status[i]  = BST_UNKNOWN;
            tbl_favor[i]   = '0;
            tbl_against[i] = '0;
        end
    end

    // Apply one command to the shadow table and return the beat it must produce.
    function automatic t_tally_beat apply_tally_op(input logic [FUNC_W-1:0] func,
                                                   input logic [ID_W-1:0]   id,
                                                   input logic [KIND_W-1:0] kind);
        t_tally_beat r;
        int          hit;
        r   = '0;
        hit = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit < 0 && tbl_status[i] != BST_UNKNOWN && tbl_key[i] == id)
                hit = i;
        end
        case (func)
            FUNC_ADD: begin
                if (hit >= 0) begin
                    r.err = ERR_PRESENT;
                    r.bst = tbl_status[hit];
                end else if (slots_used == NUM_SLOTS) begin
                    r.err = ERR_FULL;
                end else begin
                    tbl_key[slots_used]     = id;
                    tbl_status[slots_used]  = BST_PROCESSING;
                    tbl_favor[slots_used]   = '0;
                    tbl_against[slots_used] = '0;
                    slots_used++;
                    r.ok  = 1'b1;
                    r.bst = BST_PROCESSING;
                end
            end
            FUNC_VOTE: begin
                if (hit < 0) begin
                    r.err = ERR_UNKNOWN;
                end else begin
                    if (vote_total != '1) vote_total++;
                    if (kind == KIND_PREFER || kind == KIND_ACCEPT) begin
                        if (tbl_favor[hit] != '1) tbl_favor[hit]++;
                    end else if (kind == KIND_REJECT) begin
                        if (tbl_against[hit] != '1) tbl_against[hit]++;
                    end
                    // Decide once, acceptance first
                    if (tbl_status[hit] == BST_PROCESSING) begin
                        if (tbl_favor[hit] >= alpha) begin
                            tbl_status[hit] = BST_ACCEPTED;
                            if (acc_total != '1) acc_total++;
                            r.evt = EVT_ACCEPT;
                        end else if (tbl_against[hit] >= alpha) begin
                            tbl_status[hit] = BST_REJECTED;
                            if (rej_total != '1) rej_total++;
                            r.evt = EVT_REJECT;
                        end
                    end
                    r.ok  = 1'b1;
                    r.bst = tbl_status[hit];
                end
            end
            FUNC_QUERY: begin
                if (hit < 0) begin
                    r.err = ERR_UNKNOWN;
                end else begin
                    r.ok  = 1'b1;
                    r.bst = tbl_status[hit];
                end
            end
            default: ;
        endcase
        r.acc_total  = acc_total;
        r.rej_total  = rej_total;
        r.vote_total = vote_total;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] v;
        for (int i = 0; i < ID_W / 32; i++)
            v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    // Mostly ids already in the table, some one bit off a stored key, some unseen.
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] v;
        int              r;
        r = $urandom_range(99);
        if (slots_used == 0 || r >= 85)
            return fresh_id();
        v = tbl_key[$urandom_range(slots_used - 1)];
        if (r >= 75)
            v[$urandom_range(ID_W - 1)] ^= 1'b1;
        return v;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return KIND_PREFER;
        if (r < 55) return KIND_ACCEPT;
        if (r < 85) return KIND_REJECT;
        return KIND_W'($urandom_range(255));
    endfunction

    // Offer one command beat, hold it until taken, then record its expected result.
    // Leave tvalid high on return: the next call or settle() decides what follows.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                             input logic [KIND_W-1:0] kind);
        t_tally_beat expect_beat;
        while ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {kind, id};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        expect_beat = apply_tally_op(func, id, kind);
        awaited_tallies.insert(awaited_tallies.size(), expect_beat);
    endtask

    // Drop tvalid, wait for every awaited beat, then let the pipeline go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_tallies.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        alpha = value;
    endtask

    // ---------------------------------------------------------------- tests

    // Empty table: every lookup misses, and the ignored selector still answers.
    task automatic check_unknown_blocks();
        send_item(FUNC_QUERY, ID_ZERO, KIND_PREFER);
        send_item(FUNC_VOTE, ID_ONES, KIND_NONE_HI);
        send_item(FUNC_UNUSED, fresh_id(), KIND_ACCEPT);
    endtask

    // Fill the two extreme ids, then hit one again as a duplicate and query the other.
    task automatic check_add_and_duplicate();
        send_item(FUNC_ADD, ID_ZERO, KIND_PREFER);
        send_item(FUNC_ADD, ID_ONES, KIND_NONE_HI);
        send_item(FUNC_ADD, ID_ZERO, KIND_REJECT);
        send_item(FUNC_QUERY, ID_ONES, KIND_PREFER);
    endtask

    // Threshold 2: reject one block and vote past that decision, then accept the other and add it again.
    task automatic check_vote_counting();
        write_threshold(16'd2);
        send_item(FUNC_VOTE, ID_ZERO, KIND_NONE_HI);
        send_item(FUNC_VOTE, ID_ZERO, KIND_PREFER);
        send_item(FUNC_VOTE, ID_ZERO, KIND_REJECT);
        send_item(FUNC_VOTE, ID_ZERO, KIND_REJECT);
        send_item(FUNC_VOTE, ID_ZERO, KIND_ACCEPT);
        send_item(FUNC_VOTE, ID_ONES, KIND_ACCEPT);
        send_item(FUNC_VOTE, ID_ONES, KIND_PREFER);
        send_item(FUNC_ADD, ID_ONES, KIND_PREFER);
    endtask

    // Build up both counts under the top threshold, then lower it to both counts:
    // the next vote, which counts nowhere, must accept rather than reject.
    task automatic check_accept_priority();
        logic [ID_W-1:0] blk;
        blk = fresh_id();
        write_threshold('1);
        send_item(FUNC_ADD, blk, KIND_PREFER);
        for (int i = 0; i < 3; i++) begin
            send_item(FUNC_VOTE, blk, KIND_PREFER);
            send_item(FUNC_VOTE, blk, KIND_REJECT);
        end
        write_threshold(16'd3);
        send_item(FUNC_VOTE, blk, KIND_NONE_MD);
    endtask

    // Threshold zero: a first reject vote still accepts.
    task automatic check_zero_threshold();
        logic [ID_W-1:0] blk;
        blk = fresh_id();
        write_threshold('0);
        send_item(FUNC_ADD, blk, KIND_REJECT);
        send_item(FUNC_VOTE, blk, KIND_REJECT);
    endtask

    // Random mix, mostly votes on stored ids; adds are sparse so the table fills
    // partway through the run and the full-table case follows.
    task automatic run_random_traffic(input int n_items, input int gap_pct, input int stall_pct,
                                      input logic [THRESH_W-1:0] value);
        int r;
        write_threshold(value);
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if (r < 5)
                send_item(FUNC_ADD, ($urandom_range(99) < 70) ? fresh_id() : pick_id(),
                          pick_kind());
            else if (r < 65)
                send_item(FUNC_VOTE, pick_id(), pick_kind());
            else if (r < 93)
                send_item(FUNC_QUERY, pick_id(), pick_kind());
            else
                send_item(FUNC_UNUSED, pick_id(), pick_kind());
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Stall the result stream at the rate of the current phase.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                        input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_tally_beat want;
        t_tally_beat got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_tally_beat'(m_axis_tdata[$bits(t_tally_beat)-1:0]);
            if (awaited_tallies.size() == 0) begin
                $error("result beat with no command outstanding");
                mismatches++;
            end else begin
                want = awaited_tallies.pop_front();
                check_field("ok", TOTAL_W'(want.ok), TOTAL_W'(got.ok));
                check_field("error_code", TOTAL_W'(want.err), TOTAL_W'(got.err));
                check_field("block_state", TOTAL_W'(want.bst), TOTAL_W'(got.bst));
                check_field("decision_event", TOTAL_W'(want.evt), TOTAL_W'(got.evt));
                check_field("accepted_total", want.acc_total, got.acc_total);
                check_field("rejected_total", want.rej_total, got.rej_total);
                check_field("votes_total", want.vote_total, got.vote_total);
            end
        end
    end

    // Abort if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (running) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        @(posedge i_clk);

        check_unknown_blocks();
        check_add_and_duplicate();
        check_vote_counting();
        check_accept_priority();
        check_zero_threshold();

        run_random_traffic(290, 0, 0, 16'd4);
        run_random_traffic(290, 61, 0, THRESH_W'($urandom_range(2, 10)));
        run_random_traffic(290, 0, 61, 16'd1);
        run_random_traffic(290, 9, 9, THRESH_RESET);

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
